/* rtl/rbnh_pkg.sv */
// rbnh_pkg: shared types and constants for the ray/box nearest-hit block.
// Holds register indexes, reset values and fixed-point constants.
// No dependencies.
package rbnh_pkg;

	localparam int REG_W      = 24;   // width of every configuration register
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 5;    // six registers at byte addresses 0..20
	localparam int FRAC_BITS  = 8;    // origin is Q16.8, cube centre = c << 8
	localparam int HALF_UNIT  = 128;  // one half in Q.8, box face offset

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [2:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_ORIGIN_Z    = 3'd2,
		REG_RECIP_DIR_X = 3'd3,
		REG_RECIP_DIR_Y = 3'd4,
		REG_RECIP_DIR_Z = 3'd5
	} reg_idx_t;

	localparam logic signed [REG_W-1:0] ORIGIN_RST  = 24'sd0;
	localparam logic signed [REG_W-1:0] RECIP_X_RST = 24'sd65536;
	localparam logic signed [REG_W-1:0] RECIP_Y_RST = 24'sd8388607;
	localparam logic signed [REG_W-1:0] RECIP_Z_RST = 24'sd8388607;

	// per-entry flags carried through the queue
	typedef struct packed {
		logic last;
		logic hit;
	} rbnh_flags_t;

endpackage

/* rtl/rbnh_front.sv */
// rbnh_front: four-stage slab test and squared-distance pipeline.
// Uses rbnh_pkg; fed by the top level, drains into rbnh_queue.
module rbnh_front #(
	parameter int CW   = 16,
	parameter int DW   = 26,
	parameter int PW   = 50,
	parameter int DSTW = 54
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [3*CW-1:0]                     in_cube,
	input  logic                                in_last,
	input  logic signed [rbnh_pkg::REG_W-1:0]   origin [3],
	input  logic signed [rbnh_pkg::REG_W-1:0]   recip  [3],
	output logic                                out_valid,
	output logic [DSTW-1:0]                     out_dist,
	output logic [3*CW-1:0]                     out_cube,
	output rbnh_pkg::rbnh_flags_t               out_flags
);

	localparam int SQW = 2 * DW;
	localparam logic signed [DW-1:0] HALF = DW'(rbnh_pkg::HALF_UNIT);

	logic                  v_s1, v_s2, v_s3, v_s4;
	logic                  last_s1, last_s2, last_s3, last_s4;
	logic [3*CW-1:0]       cube_s1, cube_s2, cube_s3, cube_s4;
	logic signed [DW-1:0]  dlo_s1 [3];
	logic signed [DW-1:0]  dhi_s1 [3];
	logic signed [DW-1:0]  dc_s1  [3];
	logic signed [PW-1:0]  tlo_s2 [3];
	logic signed [PW-1:0]  thi_s2 [3];
	logic [SQW-1:0]        sq_s2  [3];
	logic signed [PW-1:0]  tmin_a_s3, tmin_b_s3, tmax_a_s3, tmax_b_s3;
	logic [DSTW-1:0]       dist_s3, dist_s4;
	logic                  hit_s4;

	logic signed [DW-1:0]  cen   [3];
	logic signed [DW-1:0]  org   [3];
	logic signed [PW-1:0]  tmin_c, tmax_c;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cen[a] = {{(DW-CW-rbnh_pkg::FRAC_BITS){in_cube[a*CW+CW-1]}},
			          in_cube[a*CW +: CW], {rbnh_pkg::FRAC_BITS{1'b0}}};
			org[a] = {{(DW-rbnh_pkg::REG_W){origin[a][rbnh_pkg::REG_W-1]}}, origin[a]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: face and centre offsets from the camera
	always_ff @(posedge clk) begin
		if (en) begin
			cube_s1 <= in_cube;
			last_s1 <= in_last;
			for (int a = 0; a < 3; a++) begin
				dlo_s1[a] <= cen[a] - HALF - org[a];
				dhi_s1[a] <= cen[a] + HALF - org[a];
				dc_s1[a]  <= cen[a] - org[a];
			end
		end
	end

	// stage 2: slab entry/exit times and squares; a negative reciprocal swaps faces
	always_ff @(posedge clk) begin
		if (en) begin
			cube_s2 <= cube_s1;
			last_s2 <= last_s1;
			for (int a = 0; a < 3; a++) begin
				if (recip[a][rbnh_pkg::REG_W-1]) begin
					tlo_s2[a] <= PW'(dhi_s1[a] * recip[a]);
					thi_s2[a] <= PW'(dlo_s1[a] * recip[a]);
				end else begin
					tlo_s2[a] <= PW'(dlo_s1[a] * recip[a]);
					thi_s2[a] <= PW'(dhi_s1[a] * recip[a]);
				end
				sq_s2[a] <= SQW'(dc_s1[a] * dc_s1[a]);
			end
		end
	end

	// stage 3: first half of the interval reduction, distance sum
	always_ff @(posedge clk) begin
		if (en) begin
			cube_s3   <= cube_s2;
			last_s3   <= last_s2;
			tmin_a_s3 <= (tlo_s2[0] > tlo_s2[1]) ? tlo_s2[0] : tlo_s2[1];
			tmin_b_s3 <= (tlo_s2[2] > PW'(0)) ? tlo_s2[2] : PW'(0);
			tmax_a_s3 <= (thi_s2[0] < thi_s2[1]) ? thi_s2[0] : thi_s2[1];
			tmax_b_s3 <= thi_s2[2];
			dist_s3   <= DSTW'(sq_s2[0]) + DSTW'(sq_s2[1]) + DSTW'(sq_s2[2]);
		end
	end

	assign tmin_c = (tmin_a_s3 > tmin_b_s3) ? tmin_a_s3 : tmin_b_s3;
	assign tmax_c = (tmax_a_s3 < tmax_b_s3) ? tmax_a_s3 : tmax_b_s3;

	// stage 4: hit decision
	always_ff @(posedge clk) begin
		if (en) begin
			cube_s4 <= cube_s3;
			last_s4 <= last_s3;
			dist_s4 <= dist_s3;
			hit_s4  <= (tmin_c < tmax_c);
		end
	end

	assign out_valid      = v_s4;
	assign out_dist       = dist_s4;
	assign out_cube       = cube_s4;
	assign out_flags.last = last_s4;
	assign out_flags.hit  = hit_s4;

endmodule

/* rtl/rbnh_queue.sv */
// rbnh_queue: small first-in first-out buffer between front and back.
// Uses rbnh_pkg for depth constants.
module rbnh_queue #(
	parameter int WIDTH = 106
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty,
	output logic             full
);

	logic [WIDTH-1:0]              mem_q [rbnh_pkg::QUEUE_DEPTH];
	logic [rbnh_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
	logic [rbnh_pkg::QCNT_W-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rdata     = mem_q[rptr_q];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == rbnh_pkg::QCNT_W'(rbnh_pkg::QUEUE_DEPTH));

endmodule

/* rtl/rbnh_back.sv */
// rbnh_back: running nearest-hit keeper and result output register.
// Uses rbnh_pkg; pops rbnh_queue and drives the master stream.
module rbnh_back #(
	parameter int CW   = 16,
	parameter int DSTW = 54
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  logic [DSTW-1:0]       q_dist,
	input  logic [3*CW-1:0]       q_cube,
	input  rbnh_pkg::rbnh_flags_t q_flags,
	output logic                  q_pop,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [3*CW-1:0]       res_cube,
	output logic                  res_hit,
	output logic                  res_changed
);

	logic [DSTW-1:0] best_dist_q;
	logic [3*CW-1:0] best_cube_q, prev_cube_q;
	logic            has_hit_q, prev_hit_q;

	logic            closer, nxt_has;
	logic [3*CW-1:0] nxt_cube;
	logic            out_free;

	assign out_free = !res_valid || res_ready;
	assign q_pop    = q_valid && (!q_flags.last || out_free);

	// first hit of a run always wins; later ones only if strictly nearer
	assign closer   = q_flags.hit && (!has_hit_q || (q_dist < best_dist_q));
	assign nxt_has  = has_hit_q || closer;
	assign nxt_cube = closer ? q_cube : best_cube_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q <= '1;
			best_cube_q <= '0;
			has_hit_q   <= 1'b0;
			prev_cube_q <= '0;
			prev_hit_q  <= 1'b0;
			res_valid   <= 1'b0;
		end else begin
			if (q_pop && q_flags.last) begin
				res_valid <= 1'b1;
			end else if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			if (q_pop) begin
				if (q_flags.last) begin
					prev_hit_q  <= nxt_has;
					prev_cube_q <= nxt_cube;
					best_dist_q <= '1;
					best_cube_q <= '0;
					has_hit_q   <= 1'b0;
				end else if (closer) begin
					best_dist_q <= q_dist;
					best_cube_q <= q_cube;
					has_hit_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_flags.last) begin
			res_cube    <= nxt_cube;
			res_hit     <= nxt_has;
			res_changed <= (nxt_has != prev_hit_q) ||
			               (nxt_has && prev_hit_q && (nxt_cube != prev_cube_q));
		end
	end

endmodule

/* rtl/ray_box_nearest_hit.sv */
// ray_box_nearest_hit: top level of the camera-ray / unit-cube nearest-hit finder.
// Uses rbnh_pkg, rbnh_front, rbnh_queue and rbnh_back.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------
//  s_*      | in        | s_tvalid / s_tready  | s_tdata cube x,y,z; s_tlast last cube
//  m_*      | out       | m_tvalid / m_tready  | m_tdata nearest x,y,z; m_tuser flags
//  apb      | in        | psel & penable       | six 24-bit registers at 4*index
//
//  One cube beat is taken every cycle while s_tready is high; the rate is set by
//  the fully pipelined front (nine multipliers working in parallel, one per slab
//  face and per axis square). A result becomes valid once the beat marked last has
//  passed three more front stages, the queue write and the back's output register.
//  arst_n clears all valid flags, the queue pointers, the run state and the
//  registers to their reset values.
//  m_tready low holds the result; the four-entry queue absorbs the front's
//  in-flight beats and s_tready drops only when it is full.
module ray_box_nearest_hit #(
	parameter int CUBE_COORD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// cube stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((3*CUBE_COORD_BITS+7)/8)*8-1:0] s_tdata,  // cube_x, cube_y, cube_z
	input  logic                              s_tlast,  // last_cube
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((3*CUBE_COORD_BITS+7)/8)*8-1:0] m_tdata,  // nearest_x, nearest_y, nearest_z
	output logic [1:0]                        m_tuser,  // hit_found, answer_changed
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rbnh_pkg::APB_AW-1:0]       paddr,
	input  logic [rbnh_pkg::APB_DW-1:0]       pwdata,
	output logic [rbnh_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);

	localparam int CW    = CUBE_COORD_BITS;
	localparam int BYTEW = ((3*CW+7)/8)*8;
	// offsets need room for the cube centre in Q.8 and for the 24-bit origin
	localparam int DW    = ((CW + rbnh_pkg::FRAC_BITS > rbnh_pkg::REG_W) ?
	                        (CW + rbnh_pkg::FRAC_BITS) : rbnh_pkg::REG_W) + 2;
	localparam int PW    = DW + rbnh_pkg::REG_W;
	localparam int DSTW  = 2*DW + 2;
	localparam int QW    = DSTW + 3*CW + 2;

	logic signed [rbnh_pkg::REG_W-1:0] origin_q [3];
	logic signed [rbnh_pkg::REG_W-1:0] recip_q  [3];

	logic                  wr_en;
	rbnh_pkg::reg_idx_t    reg_idx;
	logic [rbnh_pkg::REG_W-1:0] rd_val;

	logic                  f_valid;
	logic [DSTW-1:0]       f_dist;
	logic [3*CW-1:0]       f_cube;
	rbnh_pkg::rbnh_flags_t f_flags;
	logic                  f_en, q_full, q_push, q_pop, q_not_empty;
	logic [QW-1:0]         q_wdata, q_rdata;
	logic [DSTW-1:0]       q_dist;
	logic [3*CW-1:0]       q_cube;
	rbnh_pkg::rbnh_flags_t q_flags;

	logic [3*CW-1:0]       res_cube;
	logic                  res_hit, res_changed;

	// ---------------- register port ----------------
	assign pready  = 1'b1;
	assign reg_idx = rbnh_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q[0] <= rbnh_pkg::ORIGIN_RST;
			origin_q[1] <= rbnh_pkg::ORIGIN_RST;
			origin_q[2] <= rbnh_pkg::ORIGIN_RST;
			recip_q[0]  <= rbnh_pkg::RECIP_X_RST;
			recip_q[1]  <= rbnh_pkg::RECIP_Y_RST;
			recip_q[2]  <= rbnh_pkg::RECIP_Z_RST;
		end else if (wr_en) begin
			case (reg_idx)
				rbnh_pkg::REG_ORIGIN_X:    origin_q[0] <= pwdata[rbnh_pkg::REG_W-1:0];
				rbnh_pkg::REG_ORIGIN_Y:    origin_q[1] <= pwdata[rbnh_pkg::REG_W-1:0];
				rbnh_pkg::REG_ORIGIN_Z:    origin_q[2] <= pwdata[rbnh_pkg::REG_W-1:0];
				rbnh_pkg::REG_RECIP_DIR_X: recip_q[0]  <= pwdata[rbnh_pkg::REG_W-1:0];
				rbnh_pkg::REG_RECIP_DIR_Y: recip_q[1]  <= pwdata[rbnh_pkg::REG_W-1:0];
				rbnh_pkg::REG_RECIP_DIR_Z: recip_q[2]  <= pwdata[rbnh_pkg::REG_W-1:0];
				default: ; // addresses past the last register: drop the write
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rbnh_pkg::REG_ORIGIN_X:    rd_val = origin_q[0];
			rbnh_pkg::REG_ORIGIN_Y:    rd_val = origin_q[1];
			rbnh_pkg::REG_ORIGIN_Z:    rd_val = origin_q[2];
			rbnh_pkg::REG_RECIP_DIR_X: rd_val = recip_q[0];
			rbnh_pkg::REG_RECIP_DIR_Y: rd_val = recip_q[1];
			rbnh_pkg::REG_RECIP_DIR_Z: rd_val = recip_q[2];
			default:                   rd_val = '0;
		endcase
	end

	// sign-extend the 24-bit value onto the 32-bit read bus
	assign prdata = {{(rbnh_pkg::APB_DW-rbnh_pkg::REG_W){rd_val[rbnh_pkg::REG_W-1]}}, rd_val};

	// ---------------- front: slab test pipeline ----------------
	// Advance the whole front unless the last stage holds a beat and the queue is full.
	assign f_en     = !(f_valid && q_full);
	assign s_tready = f_en;

	rbnh_front #(
		.CW   (CW),
		.DW   (DW),
		.PW   (PW),
		.DSTW (DSTW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (f_en),
		.in_valid  (s_tvalid),
		.in_cube   (s_tdata[3*CW-1:0]),
		.in_last   (s_tlast),
		.origin    (origin_q),
		.recip     (recip_q),
		.out_valid (f_valid),
		.out_dist  (f_dist),
		.out_cube  (f_cube),
		.out_flags (f_flags)
	);

	// ---------------- queue between front and back ----------------
	assign q_push  = f_valid && !q_full;
	assign q_wdata = {f_flags, f_cube, f_dist};

	rbnh_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	assign q_dist  = q_rdata[DSTW-1:0];
	assign q_cube  = q_rdata[DSTW +: 3*CW];
	assign q_flags = rbnh_pkg::rbnh_flags_t'(q_rdata[QW-1 -: 2]);

	// ---------------- back: nearest-hit keeper ----------------
	rbnh_back #(
		.CW   (CW),
		.DSTW (DSTW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_not_empty),
		.q_dist      (q_dist),
		.q_cube      (q_cube),
		.q_flags     (q_flags),
		.q_pop       (q_pop),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res_cube    (res_cube),
		.res_hit     (res_hit),
		.res_changed (res_changed)
	);

	// zero-fill the cube fields up to whole bytes
	assign m_tdata = BYTEW'(res_cube);
	assign m_tuser = {res_changed, res_hit};

endmodule
